@@ hw/rtl/lrupr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants, result codes and controller/datapath bundles for the
// LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // defaults for the top-level parameters
    localparam int unsigned DEF_PROCESSES  = 16;
    localparam int unsigned DEF_PAGES      = 32;
    localparam int unsigned DEF_PAGE_BYTES = 128;
    localparam int unsigned DEF_STAMP_BITS = 32;

    // fixed field widths of the request and response
    localparam int unsigned PROC_W     = 4;
    localparam int unsigned PC_W       = 12;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned PAGE_OUT_W = 5;

    // fraction bits of the reciprocal used for the page number
    localparam int unsigned RECIP_SHIFT = 24;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_PAGE_IN   = 2'd1,
        ACT_EVICT     = 2'd2,
        ACT_NO_VICTIM = 2'd3
    } t_action;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clearing pass, one stamp entry
        logic load;       // capture request
        logic fix_quot;   // correct page number estimate
        logic scan_init;  // reset victim search
        logic scan;       // victim search step
        logic write;      // stamp the requested page
        logic finish;     // load response, advance tick
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;   // last entry of the clearing pass
        logic ok;         // active, known process, page in range
        logic need_scan;  // not resident and no free frame
        logic scan_done;  // all reads issued and evaluated
    } t_sts;

endpackage

@@ hw/rtl/lrupr_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_req_if
// Request channel: one process turn, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrupr_req_if
    import lrupr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PROC_W-1:0] process_index;
    logic              active;
    logic [PC_W-1:0]   program_counter;
    logic [MASK_W-1:0] resident_mask;
    logic [COUNT_W-1:0] page_count;
    logic              frame_available;
    logic              end_of_pass;

    modport source (
        output valid, process_index, active, program_counter, resident_mask,
               page_count, frame_available, end_of_pass,
        input  ready
    );

    modport sink (
        input  valid, process_index, active, program_counter, resident_mask,
               page_count, frame_available, end_of_pass,
        output ready
    );
endinterface

@@ hw/rtl/lrupr_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_rsp_if
// Response channel: action, requested page and victim, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrupr_rsp_if
    import lrupr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_action               action;
    logic [PAGE_OUT_W-1:0] requested_page;
    logic [PAGE_OUT_W-1:0] victim_page;

    modport source (
        output valid, action, requested_page, victim_page,
        input  ready
    );

    modport sink (
        input  valid, action, requested_page, victim_page,
        output ready
    );
endinterface

@@ hw/rtl/lrupr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_dpath
// Datapath: request registers, page number, stamp memory with clearing pass,
// victim search, tick counter and response registers.
// ----------------------------------------------------------------------------
module lrupr_dpath
    import lrupr_pkg::*;
#(
    parameter int unsigned PROCESSES  = DEF_PROCESSES,
    parameter int unsigned PAGES      = DEF_PAGES,
    parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int unsigned STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [PROC_W-1:0]     i_process_index,
    input  logic                  i_active,
    input  logic [PC_W-1:0]       i_program_counter,
    input  logic [MASK_W-1:0]     i_resident_mask,
    input  logic [COUNT_W-1:0]    i_page_count,
    input  logic                  i_frame_available,
    input  logic                  i_end_of_pass,
    output t_action               o_action,
    output logic [PAGE_OUT_W-1:0] o_requested_page,
    output logic [PAGE_OUT_W-1:0] o_victim_page
);

    localparam int unsigned DEPTH   = PROCESSES * PAGES;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned LIM_CAP = (PAGES < 32) ? PAGES : 32;
    localparam int unsigned RECIP   = (1 << RECIP_SHIFT) / PAGE_BYTES;
    localparam int unsigned PROD_W  = PC_W + RECIP_SHIFT + 1;
    localparam int unsigned BACK_W  = 2 * PC_W + 1;

    // request registers
    logic [PROC_W-1:0]  r_proc;
    logic               r_act;
    logic [PC_W-1:0]    r_pc;
    logic [MASK_W-1:0]  r_mask;
    logic [COUNT_W-1:0] r_limit;
    logic               r_frame;
    logic               r_last;
    logic [PC_W-1:0]    r_q;
    logic [ADDR_W-1:0]  r_base;

    // stamp memory and search
    logic [STAMP_BITS-1:0] mem [DEPTH];
    logic [STAMP_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [STAMP_BITS-1:0] r_tick;
    logic [STAMP_BITS-1:0] r_best;
    logic [4:0]            r_victim;
    logic                  r_found;
    logic [COUNT_W-1:0]    r_scan_idx;
    logic                  r_rd_vld;
    logic [4:0]            r_rd_idx;

    // response registers
    t_action               r_out_action;
    logic [PAGE_OUT_W-1:0] r_out_page;
    logic [PAGE_OUT_W-1:0] r_out_victim;

    logic [PROD_W-1:0]  prod;
    logic [PC_W-1:0]    q_est;
    logic [BACK_W-1:0]  back;
    logic [BACK_W-1:0]  rem;
    logic [COUNT_W-1:0] lim_in;
    logic               issue;
    logic               hit;
    logic               ok;
    logic               resident;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    t_action            action;

    // page number: reciprocal estimate, low by at most one
    assign prod  = PROD_W'(i_program_counter) * PROD_W'(RECIP);
    assign q_est = prod[PC_W+RECIP_SHIFT-1:RECIP_SHIFT];
    assign back  = BACK_W'(r_q) * BACK_W'(PAGE_BYTES);
    assign rem   = BACK_W'(r_pc) - back;

    assign lim_in = (32'(i_page_count) < LIM_CAP) ? i_page_count : COUNT_W'(LIM_CAP);

    // turn classification
    assign ok = r_act && (32'(r_proc) < PROCESSES) && (32'(r_q) < PAGES)
                && (32'(r_q) < 32);
    assign resident = r_mask[r_q[4:0]];

    assign issue   = i_cmd.scan && (r_scan_idx < r_limit);
    assign hit     = r_rd_vld && r_mask[r_rd_idx] && (r_rd_data < r_best);
    assign rd_addr = r_base + ADDR_W'(r_scan_idx);
    assign wr_addr = r_base + ADDR_W'(r_q);

    assign o_sts.clr_done  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.ok        = ok;
    assign o_sts.need_scan = ok && !resident && !r_frame;
    assign o_sts.scan_done = (r_scan_idx >= r_limit) && !r_rd_vld;

    // request capture and page number correction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_proc  <= i_process_index;
            r_act   <= i_active;
            r_pc    <= i_program_counter;
            r_mask  <= i_resident_mask;
            r_limit <= lim_in;
            r_frame <= i_frame_available;
            r_last  <= i_end_of_pass;
            r_q     <= q_est;
            r_base  <= ADDR_W'(32'(i_process_index) * PAGES);
        end else if (i_cmd.fix_quot) begin
            if (rem >= BACK_W'(PAGE_BYTES)) begin
                r_q <= r_q + PC_W'(1);
            end
        end
    end

    // stamp memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.write) begin
            mem[wr_addr] <= r_tick;
        end
        r_rd_data <= mem[rd_addr];
    end

    // clearing pass counter and tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_tick     <= STAMP_BITS'(1);
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.finish && r_last && (r_tick != '1)) begin
                r_tick <= r_tick + STAMP_BITS'(1);
            end
        end
    end

    // victim search: issue one read, evaluate the previous one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_idx <= '0;
            r_best     <= r_tick;
            r_victim   <= '0;
            r_found    <= 1'b0;
        end else if (i_cmd.scan) begin
            if (issue) begin
                r_scan_idx <= r_scan_idx + COUNT_W'(1);
                r_rd_idx   <= r_scan_idx[4:0];
            end
            if (hit) begin
                r_best   <= r_rd_data;
                r_victim <= r_rd_idx;
                r_found  <= 1'b1;
            end
        end
    end

    // result code
    always_comb begin
        if (!ok || resident) begin
            action = ACT_NONE;
        end else if (r_frame) begin
            action = ACT_PAGE_IN;
        end else if (r_found) begin
            action = ACT_EVICT;
        end else begin
            action = ACT_NO_VICTIM;
        end
    end

    // response registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_action <= action;
            r_out_page   <= r_q[PAGE_OUT_W-1:0];
            r_out_victim <= (action == ACT_EVICT) ? r_victim : '0;
        end
    end

    assign o_action         = r_out_action;
    assign o_requested_page = r_out_page;
    assign o_victim_page    = r_out_victim;

endmodule

@@ hw/rtl/lrupr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Controller: sequences clearing pass, request capture, victim search,
// stamp write and response hand-off.
// ----------------------------------------------------------------------------
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   slot_free;

    assign slot_free   = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.fix_quot = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.scan_init = 1'b1;
                if (!i_sts.ok) begin
                    n_state = S_DONE;
                end else if (i_sts.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // response valid: set on finish, dropped when taken
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.finish) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Per-process LRU page replacement with timestamps.
// ----------------------------------------------------------------------------
// One request is one process turn and gives exactly one response. After
// reset the stamp memory is cleared, one entry per cycle, through all
// PROCESSES*PAGES entries (512 by default); no request is taken meanwhile.
// An ignored turn passes the states DIV, CHECK and DONE after acceptance;
// a turn that only stamps its page adds WRITE, and one that searches a
// victim adds SCAN before WRITE. The search covers limit entries, limit
// being min(page_count, PAGES, 32): it reads one stored stamp per cycle
// through the single memory read port and ends with the last compare and
// the end check. Requests are taken one at a time; the next is accepted
// while the previous response still waits.
// The tick advances after a turn flagged end-of-pass and stops at its
// maximum.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int unsigned PROCESSES  = DEF_PROCESSES,
    parameter int unsigned PAGES      = DEF_PAGES,
    parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int unsigned STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrupr_req_if.sink   i_req,
    lrupr_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencing
    lrupr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    lrupr_dpath #(
        .PROCESSES  (PROCESSES),
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_process_index   (i_req.process_index),
        .i_active          (i_req.active),
        .i_program_counter (i_req.program_counter),
        .i_resident_mask   (i_req.resident_mask),
        .i_page_count      (i_req.page_count),
        .i_frame_available (i_req.frame_available),
        .i_end_of_pass     (i_req.end_of_pass),
        .o_action          (o_rsp.action),
        .o_requested_page  (o_rsp.requested_page),
        .o_victim_page     (o_rsp.victim_page)
    );

endmodule
